[rtl/hds_pkg.sv]
// Package for the determinant-of-Hessian stencil core.
// Holds widths, configuration register indexes and the shared structs.
// No dependencies; every other file depends on it.
package hds_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = 16;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 11;
    localparam int WREG_W     = 12;
    localparam int HREG_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int RESP_W     = 48;
    localparam int DIFF_W     = PIX_W + 3;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DET_W      = PROD_W + 4;
    localparam int SCALED_W   = DET_W + SCALE_W + 1;
    localparam int SHIFT      = 12;

    localparam logic [WREG_W-1:0]  WIDTH_RESET  = WREG_W'(640);
    localparam logic [HREG_W-1:0]  HEIGHT_RESET = HREG_W'(480);
    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_NORM_SCALE   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
        logic             frame_last;
    } t_meta;

    typedef struct packed {
        logic signed [DIFF_W-1:0] lxx;
        logic signed [DIFF_W-1:0] lyy;
        logic signed [DIFF_W-1:0] lxy4;
    } t_diff;

endpackage

[rtl/hds_pix_if.sv]
// Input channel of the stencil core: one pixel per beat.
// Depends on hds_pkg for the pixel width.
interface hds_pix_if;
    logic                      valid;
    logic                      ready;
    logic [hds_pkg::PIX_W-1:0] pixel_value;
    logic                      frame_start;

    modport source (output valid, pixel_value, frame_start, input ready);
    modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

[rtl/hds_resp_if.sv]
// Output channel of the stencil core: one response per beat.
// Depends on hds_pkg for the field widths.
interface hds_resp_if;
    logic                              valid;
    logic                              ready;
    logic signed [hds_pkg::RESP_W-1:0] response;
    logic [hds_pkg::ROW_W-1:0]         centre_row;
    logic [hds_pkg::COL_W-1:0]         centre_col;
    logic                              frame_last;

    modport source (output valid, response, centre_row, centre_col, frame_last, input ready);
    modport sink   (input valid, response, centre_row, centre_col, frame_last, output ready);
endinterface

[rtl/hessian_determinant_stencil_core.sv]
// Determinant-of-Hessian stencil core, top level.
// Depends on hds_pkg, hds_pix_if, hds_resp_if and hds_det_pipe.
//
// Pixels enter in raster order on i_pix, one per beat, frame_start marking
// the first pixel of a frame. Each pixel whose row and column are both at
// least 2 completes a 3x3 window and yields one beat on o_resp carrying the
// scaled determinant and the window centre; border pixels yield nothing.
// The configuration port writes image_width, image_height and norm_scale
// by index; write it only while the core is idle.
// Throughput is one pixel per cycle when no stall or sweep holds i_pix.ready:
// the two previous rows share one line memory word per column, read when a pixel
// is accepted and written back as it leaves the first stage, with forwarding
// when consecutive pixels hit one column. A response passes the first stage
// and the product, determinant and scaled registers of hds_det_pipe. After
// reset the core sweeps the line memory to zero, holding i_pix.ready low;
// configuration writes are taken as usual. When the receiver stalls, the
// whole pipeline holds and i_pix.ready drops until the output register is taken.
module hessian_determinant_stencil_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    hds_pix_if.sink                           i_pix,
    hds_resp_if.source                        o_resp,
    input  logic                              i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hds_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hds_pkg::*;

    logic [WREG_W-1:0]  r_width;
    logic [HREG_W-1:0]  r_height;
    logic [SCALE_W-1:0] r_scale;

    logic [WREG_W-1:0]  w_eff;
    logic [HREG_W-1:0]  h_eff;

    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   row_in;
    logic [COL_W-1:0]   col_in;

    logic               r_clr_busy;
    logic [ADDR_W-1:0]  r_clr_idx;

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [2*PIX_W-1:0] mem_wdata;

    logic               r1_v;
    logic               r1_interior;
    logic [COL_W-1:0]   r1_col;
    logic [PIX_W-1:0]   r1_pix;
    t_meta              r1_meta;
    logic               r1_fwd;
    logic [2*PIX_W-1:0] r1_fwd_data;

    logic [PIX_W-1:0]   r_win [6];
    logic [PIX_W-1:0]   top, mid;

    logic               en, accept, s1_adv;
    t_diff              diff;
    t_meta              out_meta;

    always_comb begin
        w_eff = r_width;
        if (r_width < WREG_W'(3)) begin
            w_eff = WREG_W'(3);
        end else if (r_width > WREG_W'(MAX_WIDTH)) begin
            w_eff = WREG_W'(MAX_WIDTH);
        end
        h_eff = (r_height < HREG_W'(3)) ? HREG_W'(3) : r_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_scale  <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WREG_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[HREG_W-1:0];
                CFG_NORM_SCALE:   r_scale  <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign en          = !o_resp.valid || o_resp.ready;
    assign i_pix.ready = en && !r_clr_busy;
    assign accept      = i_pix.valid && i_pix.ready;
    assign s1_adv      = en && r1_v;

    always_comb begin
        row_in = i_pix.frame_start ? '0 : r_row;
        col_in = i_pix.frame_start ? '0 : r_col;
        if ({1'b0, col_in} + WREG_W'(1) >= w_eff) begin
            n_col = '0;
            n_row = ({1'b0, row_in} + 17'd1 >= {1'b0, h_eff}) ? '0 : row_in + ROW_W'(1);
        end else begin
            n_col = col_in + COL_W'(1);
            n_row = row_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r1_v        <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + ADDR_W'(1);
                if (r_clr_idx == ADDR_W'(MAX_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (en) begin
                r1_v <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_col                <= col_in;
            r1_pix                <= i_pix.pixel_value;
            r1_interior           <= (row_in >= ROW_W'(2)) && (col_in >= COL_W'(2));
            r1_meta.centre_row    <= row_in - ROW_W'(1);
            r1_meta.centre_col    <= col_in - COL_W'(1);
            r1_meta.frame_last    <= (row_in >= h_eff - HREG_W'(1))
                                  && ({1'b0, col_in} >= w_eff - WREG_W'(1));
            r1_fwd                <= r1_v && (r1_col == col_in);
            r1_fwd_data           <= {mid, r1_pix};
        end
    end

    assign mem_we    = r_clr_busy || s1_adv;
    assign mem_waddr = r_clr_busy ? r_clr_idx : r1_col[ADDR_W-1:0];
    assign mem_wdata = r_clr_busy ? '0 : {mid, r1_pix};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[col_in[ADDR_W-1:0]];
        end
    end

    assign top = r1_fwd ? r1_fwd_data[2*PIX_W-1:PIX_W] : r_rd[2*PIX_W-1:PIX_W];
    assign mid = r1_fwd ? r1_fwd_data[PIX_W-1:0] : r_rd[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r1_pix;
        end
    end

    always_comb begin
        diff.lxx  = DIFF_W'(r_win[1]) - (DIFF_W'(r_win[4]) <<< 1) + DIFF_W'(mid);
        diff.lyy  = DIFF_W'(r_win[3]) - (DIFF_W'(r_win[4]) <<< 1) + DIFF_W'(r_win[5]);
        diff.lxy4 = DIFF_W'(top) - DIFF_W'(r_win[0]) + DIFF_W'(r_win[2]) - DIFF_W'(r1_pix);
    end

    hds_det_pipe u_det (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (r1_v && r1_interior),
        .i_diff       (diff),
        .i_meta       (r1_meta),
        .i_norm_scale (r_scale),
        .o_valid      (o_resp.valid),
        .o_response   (o_resp.response),
        .o_meta       (out_meta)
    );

    assign o_resp.centre_row = out_meta.centre_row;
    assign o_resp.centre_col = out_meta.centre_col;
    assign o_resp.frame_last = out_meta.frame_last;

endmodule

[rtl/hds_det_pipe.sv]
// Arithmetic pipeline: products, determinant, scaling by norm_scale and the
// arithmetic shift. Depends on hds_pkg; the last stage is the output register.
module hds_det_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  hds_pkg::t_diff                i_diff,
    input  hds_pkg::t_meta                i_meta,
    input  logic [hds_pkg::SCALE_W-1:0]   i_norm_scale,
    output logic                          o_valid,
    output logic signed [hds_pkg::RESP_W-1:0] o_response,
    output hds_pkg::t_meta                o_meta
);
    import hds_pkg::*;

    logic                       r_v3, r_v4, r_v5;
    logic signed [PROD_W-1:0]   r_pxy, r_pcc;
    logic signed [DET_W-1:0]    r_det;
    logic signed [SCALED_W-1:0] r_scaled;
    t_meta                      r_m3, r_m4, r_m5;
    logic signed [DET_W-1:0]    n_det;
    logic signed [SCALED_W-1:0] n_scaled;

    always_comb begin
        n_det    = (DET_W'(r_pxy) <<< 4) - DET_W'(r_pcc);
        n_scaled = SCALED_W'(r_det) * SCALED_W'($signed({1'b0, i_norm_scale}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxy    <= PROD_W'(i_diff.lxx) * PROD_W'(i_diff.lyy);
            r_pcc    <= PROD_W'(i_diff.lxy4) * PROD_W'(i_diff.lxy4);
            r_m3     <= i_meta;
            r_det    <= n_det;
            r_m4     <= r_m3;
            r_scaled <= n_scaled;
            r_m5     <= r_m4;
        end
    end

    assign o_valid    = r_v5;
    assign o_response = RESP_W'(r_scaled >>> SHIFT);
    assign o_meta     = r_m5;

endmodule

[tb/sv/tb_hessian_determinant_stencil_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for hessian_determinant_stencil_core: raster frames of random
// pixels under random source gaps and sink stalls, every response beat predicted in place.
// Depends on hds_pkg, hds_pix_if, hds_resp_if and the core.

module tb_hessian_determinant_stencil_core;
    import hds_pkg::*;

    localparam int RANDOM_PIXELS = 560;
    localparam int TAIL_PIXELS   = 96;
    localparam int DRAIN_GUARD   = 10;
    localparam longint RESP_MAX  = (64'sd1 <<< (RESP_W - 1)) - 1;
    localparam longint RESP_MIN  = -(64'sd1 <<< (RESP_W - 1));

    typedef struct packed {
        logic signed [RESP_W-1:0] response;
        t_meta                    meta;
    } t_resp_beat;

    class hessian_scoreboard;
        logic [PIX_W-1:0]   upper_line[MAX_WIDTH];
        logic [PIX_W-1:0]   middle_line[MAX_WIDTH];
        logic [PIX_W-1:0]   window[6];
        int unsigned        row_idx;
        int unsigned        col_idx;
        logic [WREG_W-1:0]  width_reg;
        logic [HREG_W-1:0]  height_reg;
        logic [SCALE_W-1:0] scale_reg;
        t_resp_beat         expected_beats[$];
        int unsigned        errors;
        int unsigned        pixels_taken;
        int unsigned        beats_checked;

        function new();
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            row_idx       = 0;
            col_idx       = 0;
            width_reg     = WIDTH_RESET;
            height_reg    = HEIGHT_RESET;
            scale_reg     = SCALE_RESET;
            errors        = 0;
            pixels_taken  = 0;
            beats_checked = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg < 3) return 3;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg < 3) ? 3 : height_reg;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = data[WREG_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = data[HREG_W-1:0];
                CFG_NORM_SCALE:   scale_reg  = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_pixel(logic [PIX_W-1:0] pix, logic fs);
            int unsigned      w;
            int unsigned      h;
            int unsigned      r;
            int unsigned      c;
            logic [PIX_W-1:0] top;
            logic [PIX_W-1:0] mid;
            longint           lxx;
            longint           lyy;
            longint           cross_term;
            longint           det;
            longint           scaled;
            t_resp_beat       beat;
            w = eff_width();
            h = eff_height();
            pixels_taken++;
            if (fs) begin
                row_idx = 0;
                col_idx = 0;
            end
            r = row_idx;
            c = col_idx;
            top = upper_line[c];
            mid = middle_line[c];
            upper_line[c]  = mid;
            middle_line[c] = pix;
            if (r >= 2 && c >= 2) begin
                lxx    = longint'(window[1]) - 2 * longint'(window[4]) + longint'(mid);
                lyy    = longint'(window[3]) - 2 * longint'(window[4]) + longint'(window[5]);
                cross_term = longint'(top) - longint'(window[0]) + longint'(window[2])
                             - longint'(pix);
                det    = 16 * lxx * lyy - cross_term * cross_term;
                scaled = (det * longint'(scale_reg)) >>> SHIFT;
                if (scaled > RESP_MAX) scaled = RESP_MAX;
                else if (scaled < RESP_MIN) scaled = RESP_MIN;
                beat.response        = scaled[RESP_W-1:0];
                beat.meta.centre_row = ROW_W'(r - 1);
                beat.meta.centre_col = COL_W'(c - 1);
                beat.meta.frame_last = (r >= h - 1) && (c >= w - 1);
                expected_beats = {expected_beats, beat};
            end
            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = top;
            window[4] = mid;
            window[5] = pix;
            if (c + 1 >= w) begin
                col_idx = 0;
                row_idx = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_idx = c + 1;
            end
        endfunction

        function void report(string field, logic signed [63:0] want, logic signed [63:0] got);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_response(logic signed [RESP_W-1:0] resp, t_meta meta);
            t_resp_beat want;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat: expected none, actual response %0d row %0d col %0d",
                         $time, resp, meta.centre_row, meta.centre_col);
                return;
            end
            want = expected_beats.pop_front();
            if (resp !== want.response) report("response", 64'(want.response), 64'(resp));
            if (meta.centre_row !== want.meta.centre_row)
                report("centre_row", 64'(want.meta.centre_row), 64'(meta.centre_row));
            if (meta.centre_col !== want.meta.centre_col)
                report("centre_col", 64'(want.meta.centre_col), 64'(meta.centre_col));
            if (meta.frame_last !== want.meta.frame_last)
                report("frame_last", 64'(want.meta.frame_last), 64'(meta.frame_last));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    hds_pix_if  pix_if ();
    hds_resp_if resp_if ();

    hessian_determinant_stencil_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_resp     (resp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hessian_scoreboard sb;
    bit                steady;
    int                src_idle_pct;
    int                sink_stall_pct;
    int                sink_hold;
    int                random_sent;
    int                cfg_writes;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            resp_if.ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            resp_if.ready <= 1'b0;
        end else if (!steady && $urandom_range(99) < sink_stall_pct) begin
            sink_hold = $urandom_range(0, 3);
            resp_if.ready <= 1'b0;
        end else begin
            resp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && resp_if.valid === 1'b1 && resp_if.ready === 1'b1)
            sb.check_response(resp_if.response,
                              {resp_if.centre_row, resp_if.centre_col, resp_if.frame_last});
    end

    function automatic logic [PIX_W-1:0] draw_pixel(int style);
        case (style)
            0: begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return '1;
                    default: return PIX_W'($urandom_range(0, 65535));
                endcase
            end
            1:       return PIX_W'(32'h8000 + $urandom_range(0, 255));
            default: return PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows the accepting rising edge, with valid still high.
    task automatic send_pixel(input logic [PIX_W-1:0] value, input logic fs);
        if (!steady && $urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= value;
        pix_if.frame_start <= fs;
        @(posedge i_clk);
        while (pix_if.ready !== 1'b1) @(posedge i_clk);
        sb.accept_pixel(value, fs);
        @(negedge i_clk);
    endtask

    task automatic stop_pixels();
        pix_if.valid       <= 1'b0;
        pix_if.frame_start <= 1'b0;
    endtask

    // Border pixels give no beat, so the core may still be busy when the
    // queue empties; the guard covers the pipeline depth.
    task automatic wait_idle();
        while (sb.expected_beats.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GUARD) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] w_data,
                              input logic [CFG_DATA_W-1:0] h_data,
                              input logic [CFG_DATA_W-1:0] s_data);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IMAGE_WIDTH;
        cfg_data <= w_data;
        @(negedge i_clk);
        sb.write_reg(CFG_IMAGE_WIDTH, w_data);
        cfg_idx  <= CFG_IMAGE_HEIGHT;
        cfg_data <= h_data;
        @(negedge i_clk);
        sb.write_reg(CFG_IMAGE_HEIGHT, h_data);
        cfg_idx  <= CFG_NORM_SCALE;
        cfg_data <= s_data;
        @(negedge i_clk);
        sb.write_reg(CFG_NORM_SCALE, s_data);
        cfg_we   <= 1'b0;
        cfg_writes += 3;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        logic [CFG_DATA_W-1:0] s_data;
        int                    frames;
        int                    rows;
        int                    n;
        int                    style;
        bit                    lead_fs;
        logic                  fs;

        pix_if.valid       = 1'b0;
        pix_if.pixel_value = '0;
        pix_if.frame_start = 1'b0;
        resp_if.ready      = 1'b1;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_IMAGE_WIDTH;
        cfg_data           = '0;
        steady             = 1'b0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        sink_hold          = 0;
        random_sent        = 0;
        cfg_writes         = 0;
        sb                 = new();
        i_rst_n            = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Out-of-range width and height both clamp to 3; a checkerboard gives the
        // largest positive determinant, then a second frame with no frame_start
        // puts the two corners up for the most negative one.
        set_config(16'd0, 16'd1, 16'hFFFF);
        for (int p = 0; p < 9; p++) send_pixel((p % 2 == 0) ? '1 : '0, p == 0);
        for (int p = 0; p < 9; p++) send_pixel((p == 2 || p == 6) ? '1 : '0, 1'b0);
        stop_pixels();
        wait_idle();

        // Narrowing the row while the column counter sits past the new end.
        set_config(16'd5, 16'd4, 16'd0);
        for (int p = 0; p < 4; p++) send_pixel(draw_pixel(0), p == 0);
        stop_pixels();
        wait_idle();
        set_config(16'd3, 16'd4, 16'd256);
        for (int p = 0; p < 3; p++) send_pixel(draw_pixel(0), 1'b0);

        while (random_sent < RANDOM_PIXELS) begin
            stop_pixels();
            wait_idle();
            case ($urandom_range(9))
                0:       w_data = CFG_DATA_W'($urandom_range(0, 2));
                1:       w_data = CFG_DATA_W'(32'hF000 | $urandom_range(3, 12));
                default: w_data = CFG_DATA_W'($urandom_range(3, 10));
            endcase
            case ($urandom_range(9))
                0:       h_data = CFG_DATA_W'($urandom_range(0, 2));
                1:       h_data = $urandom_range(1) ? 16'hFFFF
                                                    : CFG_DATA_W'($urandom_range(9, 65535));
                default: h_data = CFG_DATA_W'($urandom_range(3, 6));
            endcase
            case ($urandom_range(4))
                0:       s_data = 16'd0;
                1:       s_data = 16'hFFFF;
                2:       s_data = 16'd256;
                default: s_data = CFG_DATA_W'($urandom_range(0, 65535));
            endcase
            set_config(w_data, h_data, s_data);
            src_idle_pct   = $urandom_range(2) * 20;
            sink_stall_pct = $urandom_range(2) * 20;
            frames         = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                rows    = (sb.eff_height() > 8) ? 8 : sb.eff_height();
                n       = sb.eff_width() * rows;
                if ($urandom_range(9) == 0) n = $urandom_range(1, n);
                lead_fs = !(f == 0 && $urandom_range(4) == 0);
                style   = $urandom_range(2);
                for (int p = 0; p < n; p++) begin
                    fs = (p == 0) ? lead_fs : ($urandom_range(49) == 0);
                    send_pixel(draw_pixel(style), fs);
                    random_sent++;
                end
            end
        end

        // A back-to-back run on an oversized width, which clamps to the widest row.
        stop_pixels();
        steady = 1'b1;
        wait_idle();
        set_config(16'hFFFF, 16'd3, CFG_DATA_W'($urandom_range(0, 65535)));
        for (int p = 0; p < TAIL_PIXELS; p++)
            send_pixel(draw_pixel(p / 32 % 3), p == 0);
        stop_pixels();
        wait_idle();

        $display("Covered %0d pixels and %0d response beats over %0d register writes.",
                 sb.pixels_taken, sb.beats_checked, cfg_writes);
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
